// ===== hw/rtl/lit_pkg.sv =====
// Shared types and constants of the local interrupt timer.
`default_nettype none
package lit_pkg;

  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned REG_W   = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned VEC_W   = 8;
  localparam int unsigned PRE_W   = 7;
  localparam int unsigned DIV_W   = 4;
  localparam int unsigned MODE_W  = 2;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [REG_W-1:0] REG_ENTRY   = 6'h32;
  localparam logic [REG_W-1:0] REG_INITIAL = 6'h38;
  localparam logic [REG_W-1:0] REG_CURRENT = 6'h39;
  localparam logic [REG_W-1:0] REG_DIVIDE  = 6'h3E;

  localparam int unsigned ENTRY_MASK_BIT = 16;
  localparam int unsigned ENTRY_MODE_LSB = 17;
  localparam logic [DIV_W-1:0] DIVIDE_KEEP = 4'b1011;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;

  typedef struct packed {
    logic              bad_access;
    logic [VEC_W-1:0]  irq_vector;
    logic              irq_fire;
    logic [DATA_W-1:0] rdata;
  } result_t;

  // Divide code bits {3,1,0} = n selects 2^((n+1) mod 8); return that divisor minus one.
  function automatic logic [PRE_W-1:0] period_last(input logic [DIV_W-1:0] code);
    logic [2:0] n;
    logic [2:0] e;
    n = {code[3], code[1:0]};
    e = n + 3'd1;
    return PRE_W'((8'd1 << e) - 8'd1);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lit_core.sv =====
// Timer registers, prescaler, count-down and per-word result logic.
`default_nettype none
module lit_core #(
  parameter int unsigned COUNT_WIDTH = lit_pkg::COUNT_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [lit_pkg::CMD_W-1:0]   cmd,
  input  wire logic [lit_pkg::REG_W-1:0]   reg_index,
  input  wire logic [lit_pkg::DATA_W-1:0]  wdata,
  output lit_pkg::result_t                 result
);

  logic [lit_pkg::DIV_W-1:0]  divide_code, divide_code_next;
  logic [lit_pkg::VEC_W-1:0]  entry_vector, entry_vector_next;
  logic                       entry_mask, entry_mask_next;
  logic [lit_pkg::MODE_W-1:0] entry_mode, entry_mode_next;
  logic [COUNT_WIDTH-1:0]     initial_count, initial_count_next;
  logic [COUNT_WIDTH-1:0]     current_count, current_count_next;
  logic [lit_pkg::PRE_W-1:0]  prescale_count, prescale_count_next;

  logic [COUNT_WIDTH-1:0]     count_dec;
  logic [lit_pkg::DATA_W-1:0] entry_word;
  lit_pkg::cmd_t              op;

  assign op        = lit_pkg::cmd_t'(cmd);
  assign count_dec = current_count - COUNT_WIDTH'(1);

  always_comb begin
    entry_word = '0;
    entry_word[lit_pkg::VEC_W-1:0] = entry_vector;
    entry_word[lit_pkg::ENTRY_MASK_BIT] = entry_mask;
    entry_word[lit_pkg::ENTRY_MODE_LSB +: lit_pkg::MODE_W] = entry_mode;
  end

  always_comb begin
    divide_code_next    = divide_code;
    entry_vector_next   = entry_vector;
    entry_mask_next     = entry_mask;
    entry_mode_next     = entry_mode;
    initial_count_next  = initial_count;
    current_count_next  = current_count;
    prescale_count_next = prescale_count;
    result              = '0;
    unique case (op)
      lit_pkg::CMD_TICK: begin
        if (prescale_count >= lit_pkg::period_last(divide_code)) begin
          prescale_count_next = '0;
          if (current_count != '0) begin
            current_count_next = count_dec;
            if (count_dec == '0) begin
              if (!entry_mask) begin
                result.irq_fire   = 1'b1;
                result.irq_vector = entry_vector;
              end
              if (entry_mode == lit_pkg::MODE_PERIODIC) begin
                current_count_next = initial_count;
              end
            end
          end
        end else begin
          prescale_count_next = prescale_count + lit_pkg::PRE_W'(1);
        end
      end
      lit_pkg::CMD_WRITE: begin
        unique case (reg_index)
          lit_pkg::REG_ENTRY: begin
            entry_vector_next = wdata[lit_pkg::VEC_W-1:0];
            entry_mask_next   = wdata[lit_pkg::ENTRY_MASK_BIT];
            entry_mode_next   = wdata[lit_pkg::ENTRY_MODE_LSB +: lit_pkg::MODE_W];
          end
          lit_pkg::REG_INITIAL: begin
            initial_count_next  = wdata[COUNT_WIDTH-1:0];
            current_count_next  = wdata[COUNT_WIDTH-1:0];
            prescale_count_next = '0;
          end
          lit_pkg::REG_CURRENT: begin
          end
          lit_pkg::REG_DIVIDE: begin
            divide_code_next = wdata[lit_pkg::DIV_W-1:0] & lit_pkg::DIVIDE_KEEP;
          end
          default: begin
            result.bad_access = 1'b1;
          end
        endcase
      end
      lit_pkg::CMD_READ: begin
        unique case (reg_index)
          lit_pkg::REG_ENTRY:   result.rdata = entry_word;
          lit_pkg::REG_INITIAL: result.rdata = lit_pkg::DATA_W'(initial_count);
          lit_pkg::REG_CURRENT: result.rdata = lit_pkg::DATA_W'(current_count);
          lit_pkg::REG_DIVIDE:  result.rdata = lit_pkg::DATA_W'(divide_code);
          default:              result.bad_access = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_code    <= '0;
      entry_vector   <= '0;
      entry_mask     <= 1'b1;
      entry_mode     <= '0;
      initial_count  <= '0;
      current_count  <= '0;
      prescale_count <= '0;
    end else if (en) begin
      divide_code    <= divide_code_next;
      entry_vector   <= entry_vector_next;
      entry_mask     <= entry_mask_next;
      entry_mode     <= entry_mode_next;
      initial_count  <= initial_count_next;
      current_count  <= current_count_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/local_interrupt_timer.sv =====
// Top level of the local interrupt timer: stream ports and result register.
`default_nettype none
// Each input word is a tick, a register write, a register read or a no-op, and gives one
// result word. A word is taken every clock cycle while the result register is empty or
// being drained, so ticks may arrive back to back with none lost; the result is registered
// and appears in the cycle after acceptance. The timer state updates in the cycle a word is
// accepted, so the next word always sees the effect of the previous one.
module local_interrupt_timer #(
  parameter int unsigned COUNT_WIDTH = lit_pkg::COUNT_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // reg_index[5:0], wdata[37:6], zero pad[39:38]
  input  wire logic [lit_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  wire logic [lit_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // rdata[31:0], irq_fire[32], irq_vector[40:33], bad_access[41], zero pad[47:42]
  output logic [lit_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

  logic              accept;
  lit_pkg::result_t  result;
  lit_pkg::result_t  out_word;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lit_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .cmd       (s_axis_tuser),
    .reg_index (s_axis_tdata[lit_pkg::REG_W-1:0]),
    .wdata     (s_axis_tdata[lit_pkg::REG_W +: lit_pkg::DATA_W]),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = lit_pkg::M_TDATA_W'(out_word);

endmodule
`default_nettype wire

// ===== sim/tb_local_interrupt_timer.sv =====
// Testbench for the local interrupt timer: directed table and random words against a predictor.
`timescale 1ns / 1ps
module tb_local_interrupt_timer;

  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned QUIET_FROM   = 1400;
  localparam int unsigned DRAIN_AT     = 850;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct {
    lit_pkg::cmd_t cmd;
    logic [5:0]    idx;
    logic [31:0]   wdata;
    bit            known;
    logic [31:0]   rdata;
    bit            bad;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [lit_pkg::S_TDATA_W-1:0]  s_axis_tdata;
  logic [lit_pkg::S_TUSER_W-1:0]  s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [lit_pkg::M_TDATA_W-1:0]  m_axis_tdata;

  logic [3:0]  t_divide;
  logic [7:0]  t_vector;
  logic        t_masked;
  logic [1:0]  t_mode;
  logic [31:0] t_initial;
  logic [31:0] t_current;
  logic [6:0]  t_prescale;

  lit_pkg::result_t expected_results[$];
  stim_row_t        directed_rows[$];
  bit               word_known;
  lit_pkg::result_t word_want;
  bit               no_idle;
  int unsigned      errors;
  int unsigned      cycles;
  int unsigned      stall_left;

  local_interrupt_timer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  task automatic advance_timer(input lit_pkg::cmd_t c, input logic [5:0] idx,
                               input logic [31:0] w, output lit_pkg::result_t r);
    int unsigned period;
    logic [2:0] n;
    r = '0;
    case (c)
      lit_pkg::CMD_TICK: begin
        n = {t_divide[3], t_divide[1:0]};
        period = 32'd1 << ((int'(n) + 1) % 8);
        if (int'(t_prescale) + 1 >= period) begin
          t_prescale = '0;
          if (t_current != 0) begin
            t_current = t_current - 1;
            if (t_current == 0) begin
              if (!t_masked) begin
                r.irq_fire = 1'b1;
                r.irq_vector = t_vector;
              end
              if (t_mode == lit_pkg::MODE_PERIODIC) t_current = t_initial;
            end
          end
        end else begin
          t_prescale = 7'(t_prescale + 1);
        end
      end
      lit_pkg::CMD_WRITE: begin
        case (idx)
          lit_pkg::REG_ENTRY: begin
            t_vector = w[7:0];
            t_masked = w[lit_pkg::ENTRY_MASK_BIT];
            t_mode = w[lit_pkg::ENTRY_MODE_LSB +: 2];
          end
          lit_pkg::REG_INITIAL: begin
            t_initial = w;
            t_current = w;
            t_prescale = '0;
          end
          lit_pkg::REG_CURRENT: ;
          lit_pkg::REG_DIVIDE: t_divide = w[3:0] & lit_pkg::DIVIDE_KEEP;
          default: r.bad_access = 1'b1;
        endcase
      end
      lit_pkg::CMD_READ: begin
        case (idx)
          lit_pkg::REG_ENTRY:   r.rdata = {13'd0, t_mode, t_masked, 8'd0, t_vector};
          lit_pkg::REG_INITIAL: r.rdata = t_initial;
          lit_pkg::REG_CURRENT: r.rdata = t_current;
          lit_pkg::REG_DIVIDE:  r.rdata = {28'd0, t_divide};
          default:              r.bad_access = 1'b1;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input lit_pkg::cmd_t c, input logic [5:0] idx, input logic [31:0] w,
                         input bit known = 1'b0, input logic [31:0] rd = '0,
                         input bit bad = 1'b0);
    stim_row_t r;
    r.cmd = c;
    r.idx = idx;
    r.wdata = w;
    r.known = known;
    r.rdata = rd;
    r.bad = bad;
    directed_rows.push_back(r);
  endtask

  task automatic send_word(input lit_pkg::cmd_t c, input logic [5:0] idx,
                           input logic [31:0] w, input bit known,
                           input lit_pkg::result_t want, input bit drain);
    if (drain) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (expected_results.size() != 0) @(posedge clk);
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, w, idx};
    s_axis_tuser <= c;
    word_known <= known;
    word_want <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    lit_pkg::result_t got;
    lit_pkg::result_t want;
    lit_pkg::result_t pred;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = lit_pkg::result_t'(m_axis_tdata[41:0]);
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.rdata !== want.rdata || got.irq_fire !== want.irq_fire ||
              got.irq_vector !== want.irq_vector || got.bad_access !== want.bad_access) begin
            if (errors < 10)
              $display("mismatch: rdata %h/%h fire %b/%b vector %h/%h bad %b/%b (exp/act)",
                       want.rdata, got.rdata, want.irq_fire, got.irq_fire,
                       want.irq_vector, got.irq_vector, want.bad_access, got.bad_access);
            errors <= errors + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_timer(lit_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[37:6],
                      pred);
        expected_results.push_back(word_known ? word_want : pred);
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned pick;
    lit_pkg::cmd_t c;
    logic [5:0] idx;
    logic [31:0] w;
    lit_pkg::result_t want;

    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    word_known = 1'b0;
    word_want = '0;
    no_idle = 1'b0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    t_divide = '0;
    t_vector = '0;
    t_masked = 1'b1;
    t_mode = '0;
    t_initial = '0;
    t_current = '0;
    t_prescale = '0;

    add_row(lit_pkg::CMD_READ, lit_pkg::REG_ENTRY, 32'h0, 1'b1, 32'h0001_0000, 1'b0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_INITIAL, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_CURRENT, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_DIVIDE, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_READ, 6'h00, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(lit_pkg::CMD_WRITE, 6'h3F, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
    add_row(lit_pkg::CMD_NOP, lit_pkg::REG_ENTRY, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_TICK, 6'h3F, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_ENTRY, 32'hFFFA_FFAB);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_DIVIDE, 32'hFFFF_FFFF);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_DIVIDE, 32'h0, 1'b1, 32'h0000_000B, 1'b0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_ENTRY, 32'h0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_INITIAL, 32'h2);
    add_row(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    add_row(lit_pkg::CMD_TICK, 6'h15, 32'hA5A5_5A5A);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_CURRENT, 32'h1234_5678, 1'b1, 32'h0, 1'b0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_CURRENT, 32'h0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_DIVIDE, 32'h0000_000A);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_INITIAL, 32'hFFFF_FFFF);
    add_row(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    add_row(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_DIVIDE, 32'h0000_000B);
    add_row(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    add_row(lit_pkg::CMD_READ, lit_pkg::REG_CURRENT, 32'h0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_ENTRY, 32'h0007_00FF);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_INITIAL, 32'h1);
    add_row(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    add_row(lit_pkg::CMD_WRITE, lit_pkg::REG_INITIAL, 32'h0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      want = '0;
      want.rdata = directed_rows[k].rdata;
      want.bad_access = directed_rows[k].bad;
      send_word(directed_rows[k].cmd, directed_rows[k].idx, directed_rows[k].wdata,
                directed_rows[k].known, want, 1'b0);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i == QUIET_FROM) no_idle = 1'b1;
      pick = $urandom_range(0, 99);
      w = $urandom;
      idx = 6'($urandom_range(0, 63));
      if (pick < 55) begin
        c = lit_pkg::CMD_TICK;
      end else if (pick < 75) begin
        c = lit_pkg::CMD_WRITE;
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            idx = lit_pkg::REG_INITIAL;
            if ($urandom_range(0, 3) != 0) w = $urandom_range(0, 12);
          end
          3, 4: begin
            idx = lit_pkg::REG_ENTRY;
            w[lit_pkg::ENTRY_MASK_BIT] = ($urandom_range(0, 3) == 0);
          end
          5, 6: begin
            idx = lit_pkg::REG_DIVIDE;
            if ($urandom_range(0, 3) != 0)
              w[3:0] = $urandom_range(0, 1) ? 4'hB : {3'b000, 1'($urandom_range(0, 1))};
          end
          7: idx = lit_pkg::REG_CURRENT;
          default: ;
        endcase
      end else if (pick < 95) begin
        c = lit_pkg::CMD_READ;
        case ($urandom_range(0, 4))
          0: idx = lit_pkg::REG_ENTRY;
          1: idx = lit_pkg::REG_INITIAL;
          2: idx = lit_pkg::REG_CURRENT;
          3: idx = lit_pkg::REG_DIVIDE;
          default: ;
        endcase
      end else begin
        c = lit_pkg::CMD_NOP;
      end
      send_word(c, idx, w, 1'b0, '0, i == DRAIN_AT);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
